[src/iee_pkg.sv]
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REG_WIDTH       = 32;
   localparam int OUT_WIDTH       = 32;
   localparam int CSR_ADDR_WIDTH  = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_X_VALUE = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_Y_VALUE = 1'b1;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_Y    = 8'h79;
   localparam logic [7:0] CHAR_MUL  = 8'h2A;
   localparam logic [7:0] CHAR_DIV  = 8'h2F;
   localparam logic [7:0] CHAR_ADD  = 8'h2B;
   localparam logic [7:0] CHAR_SUB  = 8'h2D;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_DIV_ZERO  = 2'd1,
      STAT_OVERFLOW  = 2'd2,
      STAT_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MULOP_NONE = 2'd0,
      MULOP_MUL  = 2'd1,
      MULOP_DIV  = 2'd2
   } mulop_type;

   typedef enum logic [1:0] {
      OPSEL_DIGIT = 2'd0,
      OPSEL_X     = 2'd1,
      OPSEL_Y     = 2'd2
   } opsel_type;

   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_MUL     = 3'd1,
      S_DIV     = 3'd2,
      S_MUL_END = 3'd3,
      S_DIV_END = 3'd4,
      S_FINAL   = 3'd5
   } ctrl_state_type;

   typedef struct packed {
      logic       take_opv;
      opsel_type  opsel;
      logic [3:0] digit;
      logic       raise_mal;
      logic       load_term;
      logic       start_mul;
      logic       start_div;
      logic       mul_step;
      logic       div_step;
      logic       fin_mul;
      logic       fin_div;
      logic       set_mulop;
      mulop_type  mulop;
      logic       add_char;
      logic       add_minus;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic      want_operand;
      mulop_type mulop;
   } sts_type;

   function automatic status_type st_max(input status_type a, input status_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

[src/iee_ctrl.sv]
// ----------------------------------------------------------------------------
// Infix expression evaluator controller
// Decodes characters, sequences multiply/divide steps and the final sum.
// ----------------------------------------------------------------------------
module iee_ctrl import iee_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_char,
   input  logic       req_last,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + FRAC_BITS);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VALUE_WIDTH + FRAC_BITS - 1);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic is_digit, is_x, is_y, is_operand, is_muldiv, is_addsub, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   // a new word only enters in idle, when the result slot is free or draining
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_digit   = (req_char >= CHAR_ZERO) && (req_char <= CHAR_NINE);
   assign is_x       = (req_char == CHAR_X);
   assign is_y       = (req_char == CHAR_Y);
   assign is_operand = is_digit || is_x || is_y;
   assign is_muldiv  = (req_char == CHAR_MUL) || (req_char == CHAR_DIV);
   assign is_addsub  = (req_char == CHAR_ADD) || (req_char == CHAR_SUB);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.opsel    = is_x ? OPSEL_X : (is_y ? OPSEL_Y : OPSEL_DIGIT);
      cmd.digit    = 4'(req_char - CHAR_ZERO);
      cmd.mulop    = (req_char == CHAR_DIV) ? MULOP_DIV : MULOP_MUL;
      cmd.add_minus = (req_char == CHAR_SUB);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_last;
               cnt_in  = '0;
               state_in = req_last ? S_FINAL : S_IDLE;
               if (is_operand) begin
                  cmd.take_opv = 1'b1;
                  if (!sts.want_operand) begin
                     cmd.raise_mal = 1'b1;
                  end else begin
                     case (sts.mulop)
                        MULOP_MUL: begin
                           cmd.start_mul = 1'b1;
                           state_in      = S_MUL;
                        end
                        MULOP_DIV: begin
                           cmd.start_div = 1'b1;
                           state_in      = S_DIV;
                        end
                        default: cmd.load_term = 1'b1;
                     endcase
                  end
               end else if (is_muldiv) begin
                  cmd.raise_mal = sts.want_operand;
                  cmd.set_mulop = !sts.want_operand;
               end else if (is_addsub) begin
                  cmd.raise_mal = sts.want_operand;
                  cmd.add_char  = !sts.want_operand;
               end
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_MUL_END;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DIV_END;
            end
         end
         S_MUL_END: begin
            cmd.fin_mul = 1'b1;
            state_in    = last_ff ? S_FINAL : S_IDLE;
         end
         S_DIV_END: begin
            cmd.fin_div = 1'b1;
            state_in    = last_ff ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            last_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result slot must be empty whenever a result is written into it
   a_final_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> !rsp_valid_ff)
      else $error("result written while slot occupied");

   a_mul_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && cnt_ff == MUL_LAST) |=> state_ff == S_MUL_END)
      else $error("multiply did not finish after its last step");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINAL)
      else $error("result raised outside final step");

endmodule

[src/iee_datapath.sv]
// ----------------------------------------------------------------------------
// Infix expression evaluator datapath
// Sum/term registers, bit-serial multiplier and divider, saturation, result.
// ----------------------------------------------------------------------------
module iee_datapath import iee_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [REG_WIDTH-1:0]      csr_wdata,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic [OUT_WIDTH-1:0]      rsp_value,
   output status_type                rsp_status
);

   localparam int VW = VALUE_WIDTH;
   localparam int DQ_W = VALUE_WIDTH + FRAC_BITS;
   localparam int W1 = (2 * VW > DQ_W) ? 2 * VW : DQ_W;
   localparam int WW = (W1 > FRAC_BITS + 4) ? W1 : FRAC_BITS + 4;
   localparam logic [WW-1:0] HALF_W = WW'(1) << (VW - 1);

   // saturate sign/magnitude to VW bits; top bit flags overflow
   function automatic logic [VW:0] sat_mag(input logic neg, input logic [WW-1:0] mag);
      logic [WW-1:0] lim;
      logic [WW-1:0] m;
      logic          ovf;
      logic [VW-1:0] v;
      lim = neg ? HALF_W : (HALF_W - 1'b1);
      ovf = (mag > lim);
      m   = ovf ? lim : mag;
      v   = m[VW-1:0];
      if (neg) begin
         v = -v;
      end
      return {ovf, v};
   endfunction

   logic [REG_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic [VW-1:0]   sum_ff, sum_in, term_ff, term_in;
   logic            sign_ff, sign_in, expect_ff, expect_in;
   mulop_type       mulop_ff, mulop_in;
   status_type      sticky_ff, sticky_in;
   logic [VW-1:0]   opa_ff, opa_in, opb_ff, opb_in;
   logic [VW-1:0]   mhi_ff, mhi_in, mlo_ff, mlo_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [DQ_W-1:0] dq_ff, dq_in;
   logic            neg_ff, neg_in, dvd_zero_ff, dvd_zero_in, dvs_zero_ff, dvs_zero_in;
   logic [OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type      rsp_status_ff, rsp_status_in;

   logic [REG_WIDTH-1:0] reg_sel, reg_abs;
   logic            opv_neg, opv_ovf, term_neg, add_ovf, fin_ovf;
   logic [WW-1:0]   opv_mag_w, fin_mag_w;
   logic [VW-1:0]   opv, opv_mag, term_mag, add_res, fin_val;
   logic [VW+1:0]   add_ext;
   logic [VW:0]     mul_sum, rem_sh, rem_diff;
   logic            rem_ge;
   status_type      raise, fin_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff          <= '0;
         y_ff          <= '0;
         sum_ff        <= '0;
         term_ff       <= '0;
         sign_ff       <= 1'b0;
         expect_ff     <= 1'b1;
         mulop_ff      <= MULOP_NONE;
         sticky_ff     <= STAT_OK;
         rsp_status_ff <= STAT_OK;
      end else begin
         x_ff          <= x_in;
         y_ff          <= y_in;
         sum_ff        <= sum_in;
         term_ff       <= term_in;
         sign_ff       <= sign_in;
         expect_ff     <= expect_in;
         mulop_ff      <= mulop_in;
         sticky_ff     <= sticky_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      mhi_ff       <= mhi_in;
      mlo_ff       <= mlo_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      neg_ff       <= neg_in;
      dvd_zero_ff  <= dvd_zero_in;
      dvs_zero_ff  <= dvs_zero_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign sts.want_operand = expect_ff;
   assign sts.mulop        = mulop_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_X_VALUE: x_in = csr_wdata;
            CSR_Y_VALUE: y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      // operand value
      reg_sel = (cmd.opsel == OPSEL_Y) ? y_ff : x_ff;
      reg_abs = reg_sel[REG_WIDTH-1] ? -reg_sel : reg_sel;
      if (cmd.opsel == OPSEL_DIGIT) begin
         opv_neg   = 1'b0;
         opv_mag_w = WW'(cmd.digit) << FRAC_BITS;
      end else begin
         opv_neg   = reg_sel[REG_WIDTH-1];
         opv_mag_w = WW'(reg_abs);
      end
      {opv_ovf, opv} = sat_mag(opv_neg, opv_mag_w);
      opv_mag  = opv[VW-1] ? -opv : opv;
      term_neg = term_ff[VW-1];
      term_mag = term_neg ? -term_ff : term_ff;

      // saturating add/sub of sum and term, shared by operator and end of expression
      add_ext = sign_ff ? ({{2{sum_ff[VW-1]}}, sum_ff} - {{2{term_ff[VW-1]}}, term_ff})
                        : ({{2{sum_ff[VW-1]}}, sum_ff} + {{2{term_ff[VW-1]}}, term_ff});
      add_ovf = !((add_ext[VW+1:VW-1] == 3'b000) || (add_ext[VW+1:VW-1] == 3'b111));
      if (add_ovf) begin
         add_res = add_ext[VW+1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
         add_res = add_ext[VW-1:0];
      end

      // one bit per cycle multiply / restoring divide
      mul_sum  = {1'b0, mhi_ff} + (mlo_ff[0] ? {1'b0, opa_ff} : '0);
      rem_sh   = {rem_ff, dq_ff[DQ_W-1]};
      rem_ge   = (rem_sh >= {1'b0, opb_ff});
      rem_diff = rem_sh - {1'b0, opb_ff};

      // end of multiply or divide
      if (cmd.fin_div) begin
         if (dvs_zero_ff) begin
            fin_mag_w = dvd_zero_ff ? '0 : HALF_W;
         end else begin
            fin_mag_w = WW'(dq_ff);
         end
      end else begin
         fin_mag_w = WW'({mhi_ff, mlo_ff}) >> FRAC_BITS;
      end
      {fin_ovf, fin_val} = sat_mag(neg_ff, fin_mag_w);

      sum_in        = sum_ff;
      term_in       = term_ff;
      sign_in       = sign_ff;
      expect_in     = expect_ff;
      mulop_in      = mulop_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      mhi_in        = mhi_ff;
      mlo_in        = mlo_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      neg_in        = neg_ff;
      dvd_zero_in   = dvd_zero_ff;
      dvs_zero_in   = dvs_zero_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      raise         = STAT_OK;
      fin_status    = st_max(sticky_ff, expect_ff ? STAT_MALFORMED :
                             (add_ovf ? STAT_OVERFLOW : STAT_OK));

      if (cmd.take_opv && opv_ovf) begin
         raise = st_max(raise, STAT_OVERFLOW);
      end
      if (cmd.raise_mal) begin
         raise = st_max(raise, STAT_MALFORMED);
      end
      if (cmd.load_term) begin
         term_in   = opv;
         expect_in = 1'b0;
      end
      if (cmd.start_mul) begin
         opa_in = term_mag;
         mlo_in = opv_mag;
         mhi_in = '0;
         neg_in = term_neg ^ opv[VW-1];
      end
      if (cmd.start_div) begin
         opb_in      = opv_mag;
         rem_in      = '0;
         dq_in       = DQ_W'(term_mag) << FRAC_BITS;
         neg_in      = term_neg ^ opv[VW-1];
         dvd_zero_in = (term_mag == '0);
         dvs_zero_in = (opv_mag == '0);
      end
      if (cmd.mul_step) begin
         mhi_in = mul_sum[VW:1];
         mlo_in = {mul_sum[0], mlo_ff[VW-1:1]};
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
         dq_in  = {dq_ff[DQ_W-2:0], rem_ge};
      end
      if (cmd.fin_mul || cmd.fin_div) begin
         term_in   = fin_val;
         expect_in = 1'b0;
         if (fin_ovf) begin
            raise = st_max(raise, STAT_OVERFLOW);
         end
         if (cmd.fin_div && dvs_zero_ff) begin
            raise = st_max(raise, STAT_DIV_ZERO);
         end
      end
      if (cmd.set_mulop) begin
         mulop_in  = cmd.mulop;
         expect_in = 1'b1;
      end
      if (cmd.add_char) begin
         sum_in    = add_res;
         sign_in   = cmd.add_minus;
         mulop_in  = MULOP_NONE;
         expect_in = 1'b1;
         if (add_ovf) begin
            raise = st_max(raise, STAT_OVERFLOW);
         end
      end
      sticky_in = st_max(sticky_ff, raise);

      if (cmd.finish) begin
         rsp_status_in = fin_status;
         rsp_value_in  = (fin_status == STAT_MALFORMED) ? '0 : OUT_WIDTH'($signed(add_res));
         sum_in        = '0;
         term_in       = '0;
         sign_in       = 1'b0;
         mulop_in      = MULOP_NONE;
         expect_in     = 1'b1;
         sticky_in     = STAT_OK;
      end
   end

endmodule

[src/infix_expression_evaluator_core.sv]
// Operand after '*': shift-add multiplier, one bit per cycle. Operand after
// '/': restoring divider, one quotient bit per cycle (Q16.16 by default).
// Last word: a final state forms the final sum, then the result sits in an
// output register until taken. Synchronous active-high reset clears the
// evaluation state and sets x_value and y_value to zero.
// ----------------------------------------------------------------------------
// Infix expression evaluator core
// Streams characters of a two-precedence expression and returns its value.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core import iee_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] char_code
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,   // [31:0] value, [33:32] status
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [REG_WIDTH-1:0]      csr_wdata
);

   cmd_type              cmd;
   sts_type              sts;
   logic [OUT_WIDTH-1:0] value;
   status_type           status;

   iee_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_last   (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iee_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_value  (value),
      .rsp_status (status)
   );

   assign rsp_tdata = {6'b0, status, value};

endmodule

[verif/infix_expression_evaluator_core_test.sv]
// ----------------------------------------------------------------------------
// Infix expression evaluator core testbench
// Streams expressions in, one character per word, and checks each value and
// status word against a Q16.16 evaluator kept alongside. The run goes through
// directed corner cases, then random well-formed, broken and noisy
// expressions under several x/y settings and several idling patterns.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core_test import iee_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC          = FRAC_BITS_DEF;
   localparam int          SETTLE_CYCLES = 2 * (VALUE_WIDTH_DEF + FRAC_BITS_DEF + 2);
   localparam int          HOLD_CYCLES   = 400;
   localparam longint      VALUE_MAX     = 64'sd2147483647;
   localparam longint      VALUE_MIN     = -64'sd2147483648;
   localparam logic [7:0]  CHAR_SPACE    = 8'h20;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_word_type;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [39:0]               rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = CSR_X_VALUE;
   logic [REG_WIDTH-1:0]      csr_wdata  = '0;

   char_word_type pending_chars[$];
   result_type    expected_results[$];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   logic        hold_request       = 1'b0;
   logic        hold_done          = 1'b0;
   int unsigned hold_left          = 0;

   int unsigned phase_chars    = 0;
   int unsigned chars_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned settings_used  = 0;
   int unsigned mismatch_count = 0;
   int unsigned status_seen[4] = '{0, 0, 0, 0};

   // evaluator state and register copies
   logic [31:0] x_reg = '0;
   logic [31:0] y_reg = '0;
   longint      eval_sum          = 0;
   longint      eval_term         = 0;
   logic        eval_minus        = 1'b0;
   mulop_type   eval_mulop        = MULOP_NONE;
   logic        eval_want_operand = 1'b1;
   status_type  eval_status       = STAT_OK;

   infix_expression_evaluator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Q16.16 evaluator
   // ------------------------------------------------------------------------
   function automatic void raise_status(input status_type code);
      if (code > eval_status) begin
         eval_status = code;
      end
   endfunction

   function automatic longint clamp_value(input longint v);
      if (v > VALUE_MAX) begin
         raise_status(STAT_OVERFLOW);
         return VALUE_MAX;
      end
      if (v < VALUE_MIN) begin
         raise_status(STAT_OVERFLOW);
         return VALUE_MIN;
      end
      return v;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // truncates toward zero by working on magnitudes
   function automatic longint fixed_mul(input longint a, input longint b);
      longint prod;
      prod = (magnitude(a) * magnitude(b)) >> FRAC;
      return clamp_value(((a < 0) != (b < 0)) ? -prod : prod);
   endfunction

   function automatic longint fixed_div(input longint a, input longint b);
      longint quo;
      if (b == 0) begin
         raise_status(STAT_DIV_ZERO);
         if (a == 0) begin
            return 0;
         end
         // positive dividend saturates one past the top, so it flags overflow too
         return clamp_value((a < 0) ? VALUE_MIN : VALUE_MAX + 1);
      end
      quo = (magnitude(a) << FRAC) / magnitude(b);
      return clamp_value(((a < 0) != (b < 0)) ? -quo : quo);
   endfunction

   task automatic evaluate_char(input logic [7:0] code, input logic last);
      logic       is_operand;
      longint     opv;
      longint     total;
      result_type r;
      is_operand = 1'b1;
      opv        = 0;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         opv = longint'(code - CHAR_ZERO) << FRAC;
      end else if (code == CHAR_X) begin
         opv = longint'($signed(x_reg));
      end else if (code == CHAR_Y) begin
         opv = longint'($signed(y_reg));
      end else begin
         is_operand = 1'b0;
      end

      if (is_operand) begin
         if (!eval_want_operand) begin
            raise_status(STAT_MALFORMED);
         end else begin
            case (eval_mulop)
               MULOP_MUL: eval_term = fixed_mul(eval_term, opv);
               MULOP_DIV: eval_term = fixed_div(eval_term, opv);
               default:   eval_term = opv;
            endcase
            eval_want_operand = 1'b0;
         end
      end else if (code == CHAR_MUL || code == CHAR_DIV) begin
         if (eval_want_operand) begin
            raise_status(STAT_MALFORMED);
         end else begin
            eval_mulop        = (code == CHAR_MUL) ? MULOP_MUL : MULOP_DIV;
            eval_want_operand = 1'b1;
         end
      end else if (code == CHAR_ADD || code == CHAR_SUB) begin
         if (eval_want_operand) begin
            raise_status(STAT_MALFORMED);
         end else begin
            eval_sum = clamp_value(eval_minus ? eval_sum - eval_term : eval_sum + eval_term);
            eval_minus        = (code == CHAR_SUB);
            eval_mulop        = MULOP_NONE;
            eval_want_operand = 1'b1;
         end
      end

      if (last) begin
         total = 0;
         if (eval_want_operand) begin
            raise_status(STAT_MALFORMED);
         end else begin
            total = clamp_value(eval_minus ? eval_sum - eval_term : eval_sum + eval_term);
         end
         if (eval_status == STAT_MALFORMED) begin
            total = 0;
         end
         r.value  = total[31:0];
         r.status = eval_status;
         expected_results.insert(expected_results.size(), r);
         eval_sum          = 0;
         eval_term         = 0;
         eval_minus        = 1'b0;
         eval_mulop        = MULOP_NONE;
         eval_want_operand = 1'b1;
         eval_status       = STAT_OK;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers queued characters, folds each accepted word into the
   // evaluator
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      char_word_type w;
      logic          offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            evaluate_char(req_tdata, req_tlast);
            chars_sent++;
         end
         if (!req_tvalid || req_tready) begin
            offer = (pending_chars.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
            if (offer) begin
               w = pending_chars.pop_front();
               req_tdata <= w.code;
               req_tlast <= w.last;
            end
            req_tvalid <= offer;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word: value %h status %0d",
                   rsp_tdata[31:0], rsp_tdata[33:32]);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[33:32] !== want.status) begin
               $error("status: expected %s, got %0d", want.status.name(), rsp_tdata[33:32]);
               mismatch_count++;
            end
            status_seen[want.status]++;
            results_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] code, input logic last);
      char_word_type w;
      w.code = code;
      w.last = last;
      pending_chars.insert(pending_chars.size(), w);
      phase_chars++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] random_operand();
      case ($urandom_range(5))
         4:       return CHAR_X;
         5:       return CHAR_Y;
         default: return CHAR_ZERO + 8'($urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(3))
         0:       return CHAR_ADD;
         1:       return CHAR_SUB;
         2:       return CHAR_MUL;
         default: return CHAR_DIV;
      endcase
   endfunction

   function automatic logic [31:0] pick_setting();
      case ($urandom_range(4))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return $urandom();
         // roughly -10.0 .. +11.0
         default: return ($urandom_range(20) << 16) - (32'd10 << 16) + $urandom_range(65535);
      endcase
   endfunction

   // mostly well-formed, some with one fault, some raw bytes
   task automatic queue_expression();
      logic [7:0]  codes[$];
      int unsigned operands;
      int unsigned kind;
      kind = $urandom_range(19);
      if (kind < 2) begin
         repeat ($urandom_range(1, 8)) begin
            push_char(8'($urandom()), $urandom_range(5) == 0);
         end
         push_char(8'($urandom()), 1'b1);
         return;
      end
      operands = $urandom_range(1, 6);
      for (int i = 0; i < operands; i++) begin
         if (i != 0) begin
            codes.insert(codes.size(), random_operator());
         end
         if ($urandom_range(7) == 0) begin
            codes.insert(codes.size(), CHAR_SPACE);
         end
         codes.insert(codes.size(), random_operand());
      end
      if (kind < 5) begin
         case ($urandom_range(4))
            0:       codes.insert($urandom_range(codes.size()), random_operand());
            1:       codes.insert($urandom_range(codes.size()), random_operator());
            2:       codes.push_front(random_operator());
            3:       codes.insert(codes.size(), random_operator());
            default: codes = {CHAR_SPACE};
         endcase
      end
      foreach (codes[i]) begin
         push_char(codes[i], i == codes.size() - 1);
      end
   endtask

   task automatic write_reg(input logic [CSR_ADDR_WIDTH-1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= data;
      if (index == CSR_X_VALUE) begin
         x_reg = data;
      end else begin
         y_reg = data;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned count, input logic [31:0] x_set,
                            input logic [31:0] y_set, input logic pressure);
      wait_idle();
      write_reg(CSR_X_VALUE, x_set);
      write_reg(CSR_Y_VALUE, y_set);
      settings_used++;
      @(negedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (pressure) begin
         hold_request = 1'b1;
      end
      phase_chars = 0;
      while (phase_chars < count) begin
         queue_expression();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: x at the top of the range, y at the bottom
      write_reg(CSR_X_VALUE, 32'h7FFF_FFFF);
      write_reg(CSR_Y_VALUE, 32'h8000_0000);
      settings_used++;
      @(negedge clock);
      push_text("9");
      push_text("x+x");
      push_text("y-x");
      push_text("x*y");
      push_text("7/0");
      push_text("0/0");
      push_text("y/0");
      push_text("+");
      push_text("12");
      push_text(" ");
      push_text("3*");

      run_phase(0, 0, 250, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      run_phase(85, 0, 200, pick_setting(), pick_setting(), 1'b0);
      run_phase(0, 85, 200, pick_setting(), pick_setting(), 1'b0);
      run_phase(30, 30, 200, 32'h0003_0000, 32'hFFFF_8000, 1'b1);
      run_phase(0, 0, 150, 32'h0000_0000, 32'h0000_0000, 1'b0);
      wait_idle();

      $display("%0d characters streamed under %0d x/y settings, %0d results checked",
               chars_sent, settings_used, results_seen);
      $display("results by status: ok %0d, divide by zero %0d, overflow %0d, malformed %0d",
               status_seen[STAT_OK], status_seen[STAT_DIV_ZERO],
               status_seen[STAT_OVERFLOW], status_seen[STAT_MALFORMED]);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_800_000;
      $error("run timed out with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
